// ===== rtl/line_pixel_generator_top_defines.svh =====
// Assertion macros for the line pixel generator checker.
`ifndef LINE_PIXEL_GENERATOR_TOP_DEFINES_SVH
`define LINE_PIXEL_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LPG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpg check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LPG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpg check failed");

`endif

// ===== rtl/lpg_pkg.sv =====
// Shared constants and types for the line pixel generator.
`timescale 1ns / 1ps
package lpg_pkg;

  localparam int COLOR_W = 8;

  // operation codes of an input word
  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // per-line control flags
  typedef struct packed {
    logic active;
    logic major_is_x;
    logic maj_neg;     // major coordinate steps downward
  } line_flags_t;

endpackage

// ===== rtl/lpg_in_if.sv =====
// Input channel: operation, endpoints and color.
`timescale 1ns / 1ps
interface lpg_in_if #(
  parameter int X_W = 9,
  parameter int Y_W = 8
);
  import lpg_pkg::*;

  logic               valid;
  logic               ready;
  logic               operation;
  logic [X_W-1:0]     start_x;
  logic [Y_W-1:0]     start_y;
  logic [X_W-1:0]     end_x;
  logic [Y_W-1:0]     end_y;
  logic [COLOR_W-1:0] color;

  modport source (output valid, operation, start_x, start_y, end_x, end_y, color,
                  input ready);
  modport sink (input valid, operation, start_x, start_y, end_x, end_y, color,
                output ready);
endinterface

// ===== rtl/lpg_out_if.sv =====
// Result channel: one pixel per word.
`timescale 1ns / 1ps
interface lpg_out_if #(
  parameter int X_W = 9,
  parameter int Y_W = 8
);
  import lpg_pkg::*;

  logic               valid;
  logic               ready;
  logic [X_W-1:0]     pixel_x;
  logic [Y_W-1:0]     pixel_y;
  logic [COLOR_W-1:0] pixel_color;
  logic               last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel,
                  input ready);
  modport sink (input valid, pixel_x, pixel_y, pixel_color, last_pixel,
                output ready);
endinterface

// ===== rtl/lpg_setup.sv =====
// Line setup: deltas, major axis choice and step direction from two endpoints.
`timescale 1ns / 1ps
module lpg_setup #(
  parameter int X_W = 9,
  parameter int Y_W = 8,
  parameter int CW  = 9
) (
  input  logic [X_W-1:0]            start_x,
  input  logic [Y_W-1:0]            start_y,
  input  logic [X_W-1:0]            end_x,
  input  logic [Y_W-1:0]            end_y,
  output lpg_pkg::line_flags_t      flags,
  output logic [CW-1:0]             maj_org,
  output logic [CW-1:0]             min_org,
  output logic signed [CW:0]        min_d,
  output logic [CW-1:0]             maj_len
);
  import lpg_pkg::*;

  logic signed [CW:0] dx;
  logic signed [CW:0] dy;
  logic signed [CW:0] ax_full;
  logic signed [CW:0] ay_full;
  logic [CW-1:0]      ax;
  logic [CW-1:0]      ay;
  logic               major_is_x;

  always_comb begin
    dx = signed'((CW+1)'(end_x)) - signed'((CW+1)'(start_x));
    dy = signed'((CW+1)'(end_y)) - signed'((CW+1)'(start_y));
    ax_full = dx[CW] ? -dx : dx;
    ay_full = dy[CW] ? -dy : dy;
    ax = ax_full[CW-1:0];
    ay = ay_full[CW-1:0];
    major_is_x = ax > ay;  // tie goes to y

    maj_len          = major_is_x ? ax : ay;
    min_d            = major_is_x ? dy : dx;
    maj_org          = major_is_x ? CW'(start_x) : CW'(start_y);
    min_org          = major_is_x ? CW'(start_y) : CW'(start_x);
    flags.active     = maj_len != '0;
    flags.major_is_x = major_is_x;
    flags.maj_neg    = major_is_x ? dx[CW] : dy[CW];
  end

endmodule

// ===== rtl/lpg_stepper.sv =====
// Line stepper: current pixel and exact error accumulator for the minor axis.
`timescale 1ns / 1ps
module lpg_stepper #(
  parameter int CW = 9
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  logic                  step,
  input  lpg_pkg::line_flags_t  init_flags,
  input  logic [CW-1:0]         init_maj_org,
  input  logic [CW-1:0]         init_min_org,
  input  logic signed [CW:0]    init_min_d,
  input  logic [CW-1:0]         init_maj_len,
  output lpg_pkg::line_flags_t  flags,
  output logic [CW-1:0]         maj_pos,
  output logic [CW-1:0]         min_pos,
  output logic                  last
);
  import lpg_pkg::*;

  line_flags_t        flags_r, flags_nxt;
  logic [CW-1:0]      maj_pos_r, maj_pos_nxt;
  logic [CW-1:0]      min_pos_r, min_pos_nxt;
  logic signed [CW:0] min_d_r, min_d_nxt;
  logic [CW-1:0]      maj_len_r, maj_len_nxt;
  logic [CW-1:0]      rem_r, rem_nxt;        // pixels left, this one included
  logic [CW-1:0]      err_r, err_nxt;        // 0 <= err < maj_len

  logic signed [CW+1:0] e_sum;
  logic signed [CW+1:0] len_s;
  logic signed [CW+1:0] e_adj;

  assign last = rem_r == CW'(1);

  always_comb begin
    flags_nxt   = flags_r;
    maj_pos_nxt = maj_pos_r;
    min_pos_nxt = min_pos_r;
    min_d_nxt   = min_d_r;
    maj_len_nxt = maj_len_r;
    rem_nxt     = rem_r;
    err_nxt     = err_r;

    e_sum = signed'({2'b00, err_r}) + signed'({min_d_r[CW], min_d_r});
    len_s = signed'({2'b00, maj_len_r});
    e_adj = e_sum;

    if (load) begin
      flags_nxt   = init_flags;
      maj_pos_nxt = init_maj_org;
      min_pos_nxt = init_min_org;
      min_d_nxt   = init_min_d;
      maj_len_nxt = init_maj_len;
      rem_nxt     = init_maj_len;
      err_nxt     = '0;
    end else if (step) begin
      maj_pos_nxt = flags_r.maj_neg ? maj_pos_r - CW'(1) : maj_pos_r + CW'(1);
      rem_nxt     = rem_r - CW'(1);
      if (e_sum >= len_s) begin
        e_adj       = e_sum - len_s;
        min_pos_nxt = min_pos_r + CW'(1);
      end else if (e_sum[CW+1]) begin
        e_adj       = e_sum + len_s;
        min_pos_nxt = min_pos_r - CW'(1);
      end
      err_nxt = e_adj[CW-1:0];
      if (last) begin
        flags_nxt.active = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r <= flags_nxt;
    end
    maj_pos_r <= maj_pos_nxt;
    min_pos_r <= min_pos_nxt;
    min_d_r   <= min_d_nxt;
    maj_len_r <= maj_len_nxt;
    rem_r     <= rem_nxt;
    err_r     <= err_nxt;
  end

  assign flags   = flags_r;
  assign maj_pos = maj_pos_r;
  assign min_pos = min_pos_r;

endmodule

// ===== rtl/line_pixel_generator_top.sv =====
// Line pixel generator top level: input register, setup, stepper, result register.
`timescale 1ns / 1ps
// Usage
//   in_word  : valid/ready channel. operation = OP_START loads start/end points
//              and color and yields no pixel; OP_ADVANCE yields the next pixel
//              of the active line, or nothing if no line is active.
//   out_word : valid/ready channel, one pixel word per productive advance, with
//              last_pixel set on the final pixel (end point is not drawn).
// Timing
//   A word is held in the input register and processed from there; the pixel
//   of an advance goes into the result register and is offered on out_word.
//   One word per cycle sustained while out_word takes each pixel: the stepper
//   does one accumulator add, compare and correct per pixel, and the result
//   register frees the input side.
// Stalls
//   While out_word holds a pixel that is not taken, an advance that would give
//   a pixel waits in the input register and in_word.ready drops. Starts and
//   idle advances keep flowing. A start during a line drops the rest of it.
// Reset
//   rst_n (sync, active low) clears both valid flags and the line state; no
//   line is active afterward.
module line_pixel_generator_top #(
  parameter int SCREEN_COLS = 320,
  parameter int SCREEN_ROWS = 200
) (
  input logic      clk,
  input logic      rst_n,
  lpg_in_if.sink   in_word,
  lpg_out_if.source out_word
);
  import lpg_pkg::*;

  localparam int X_W = $clog2(SCREEN_COLS);
  localparam int Y_W = $clog2(SCREEN_ROWS);
  localparam int CW  = (X_W > Y_W) ? X_W : Y_W;

  // input register
  logic               in_v_r, in_v_nxt;
  logic               op_r;
  logic [X_W-1:0]     sx_r;
  logic [Y_W-1:0]     sy_r;
  logic [X_W-1:0]     ex_r;
  logic [Y_W-1:0]     ey_r;
  logic [COLOR_W-1:0] color_r;
  logic [COLOR_W-1:0] line_color_r, line_color_nxt;

  // result register
  logic               out_v_r, out_v_nxt;
  logic [X_W-1:0]     px_r, px_nxt;
  logic [Y_W-1:0]     py_r, py_nxt;
  logic [COLOR_W-1:0] pc_r, pc_nxt;
  logic               last_r, last_nxt;

  line_flags_t        init_flags;
  logic [CW-1:0]      init_maj_org;
  logic [CW-1:0]      init_min_org;
  logic signed [CW:0] init_min_d;
  logic [CW-1:0]      init_maj_len;
  line_flags_t        flags;
  logic [CW-1:0]      maj_pos;
  logic [CW-1:0]      min_pos;
  logic               last;

  logic in_take;
  logic process;
  logic load;
  logic step;

  // an item needs the result register only when it makes a pixel
  assign process = in_v_r && ((op_r == OP_START) || !flags.active ||
                              !out_v_r || out_word.ready);
  assign load    = process && (op_r == OP_START);
  assign step    = process && (op_r == OP_ADVANCE) && flags.active;
  assign in_word.ready = !in_v_r || process;
  assign in_take = in_word.valid && in_word.ready;

  lpg_setup #(
    .X_W (X_W),
    .Y_W (Y_W),
    .CW  (CW)
  ) u_setup (
    .start_x (sx_r),
    .start_y (sy_r),
    .end_x   (ex_r),
    .end_y   (ey_r),
    .flags   (init_flags),
    .maj_org (init_maj_org),
    .min_org (init_min_org),
    .min_d   (init_min_d),
    .maj_len (init_maj_len)
  );

  lpg_stepper #(
    .CW (CW)
  ) u_stepper (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (load),
    .step         (step),
    .init_flags   (init_flags),
    .init_maj_org (init_maj_org),
    .init_min_org (init_min_org),
    .init_min_d   (init_min_d),
    .init_maj_len (init_maj_len),
    .flags        (flags),
    .maj_pos      (maj_pos),
    .min_pos      (min_pos),
    .last         (last)
  );

  always_comb begin
    in_v_nxt       = in_take ? 1'b1 : (process ? 1'b0 : in_v_r);
    line_color_nxt = load ? color_r : line_color_r;

    out_v_nxt = out_v_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    pc_nxt    = pc_r;
    last_nxt  = last_r;
    if (step) begin
      out_v_nxt = 1'b1;
      px_nxt    = flags.major_is_x ? maj_pos[X_W-1:0] : min_pos[X_W-1:0];
      py_nxt    = flags.major_is_x ? min_pos[Y_W-1:0] : maj_pos[Y_W-1:0];
      pc_nxt    = line_color_r;
      last_nxt  = last;
    end else if (out_word.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
    if (in_take) begin
      op_r    <= in_word.operation;
      sx_r    <= in_word.start_x;
      sy_r    <= in_word.start_y;
      ex_r    <= in_word.end_x;
      ey_r    <= in_word.end_y;
      color_r <= in_word.color;
    end
    line_color_r <= line_color_nxt;
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    pc_r         <= pc_nxt;
    last_r       <= last_nxt;
  end

  assign out_word.valid       = out_v_r;
  assign out_word.pixel_x     = px_r;
  assign out_word.pixel_y     = py_r;
  assign out_word.pixel_color = pc_r;
  assign out_word.last_pixel  = last_r;

endmodule

// ===== rtl/lpg_checker.sv =====
// Port-level checker for the line pixel generator, bound to the top level.
`timescale 1ns / 1ps
`include "line_pixel_generator_top_defines.svh"
module lpg_checker #(
  parameter int X_W = 9,
  parameter int Y_W = 8
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_operation,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [X_W-1:0]              pixel_x,
  input logic [Y_W-1:0]              pixel_y,
  input logic [lpg_pkg::COLOR_W-1:0] pixel_color,
  input logic                        last_pixel
);
  import lpg_pkg::*;

  logic adv_seen_r;
  logic [X_W+Y_W+COLOR_W:0] pix_bus;

  assign pix_bus = {pixel_x, pixel_y, pixel_color, last_pixel};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adv_seen_r <= 1'b0;
    end else if (in_valid && in_ready && (in_operation == OP_ADVANCE)) begin
      adv_seen_r <= 1'b1;
    end
  end

  // held pixel stays put
  `LPG_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pix_bus))
  // a pixel only follows some accepted advance
  `LPG_ASSERT_NOW(a_pixel_after_adv, out_valid, adv_seen_r)
  // input back-pressure comes only from a stalled result
  `LPG_ASSERT_NOW(a_ready_cause, !in_ready, out_valid && !out_ready)
  // a result word leaves only when taken
  `LPG_ASSERT_NOW(a_drop_taken, $fell(out_valid), $past(out_ready))

endmodule

bind line_pixel_generator_top lpg_checker #(
  .X_W (X_W),
  .Y_W (Y_W)
) u_lpg_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_word.valid),
  .in_ready     (in_word.ready),
  .in_operation (in_word.operation),
  .out_valid    (out_word.valid),
  .out_ready    (out_word.ready),
  .pixel_x      (out_word.pixel_x),
  .pixel_y      (out_word.pixel_y),
  .pixel_color  (out_word.pixel_color),
  .last_pixel   (out_word.last_pixel)
);
